// ----- sv/ulpe_pkg.sv -----
// Shared types, constants and parsing functions of the uri-list path extractor.
package ulpe_pkg;

  localparam int MaxResults   = 4;
  localparam int QueueDepthDf = 4;

  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChLowE    = 8'h65;
  localparam logic [7:0] ChLowF    = 8'h66;
  localparam logic [7:0] ChLowI    = 8'h69;
  localparam logic [7:0] ChLowL    = 8'h6C;

  typedef enum logic [3:0] {
    PH_LINE_START = 4'd0,
    PH_SKIP       = 4'd1,
    PH_F          = 4'd2,
    PH_FI         = 4'd3,
    PH_FIL        = 4'd4,
    PH_FILE       = 4'd5,
    PH_COLON      = 4'd6,
    PH_COLON_SL   = 4'd7,
    PH_AUTHORITY  = 4'd8,
    PH_PATH       = 4'd9
  } phase_e;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       byte_valid;
    logic       path_end;
  } res_t;

  // All results caused by one input beat.
  typedef struct packed {
    logic [2:0]            cnt;
    res_t [MaxResults-1:0] res;
  } bundle_t;

  typedef struct packed {
    phase_e     phase;
    logic       held_percent;
    logic [7:0] held_digit;
    logic       held_digit_valid;
    logic       held_cr;
  } pstate_t;

  typedef struct packed {
    pstate_t st;
    bundle_t out;
  } ctx_t;

  // {valid, value} of a hex digit
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Appends one result; extra results beyond the bundle size are dropped.
  function automatic ctx_t put_result(ctx_t x, logic [7:0] b, logic v);
    ctx_t y;
    y = x;
    if (y.out.cnt < 3'(MaxResults)) begin
      y.out.res[y.out.cnt[1:0]].path_byte  = b;
      y.out.res[y.out.cnt[1:0]].byte_valid = v;
      y.out.res[y.out.cnt[1:0]].path_end   = 1'b0;
      y.out.cnt = y.out.cnt + 3'd1;
    end
    return y;
  endfunction

  function automatic ctx_t clear_escape(ctx_t x);
    ctx_t y;
    y = x;
    y.st.held_digit_valid = 1'b0;
    y.st.held_percent     = 1'b0;
    y.st.held_digit       = '0;
    return y;
  endfunction

  // Percent decoder for path content.
  function automatic ctx_t decode_byte(ctx_t x, logic [7:0] c);
    ctx_t       y;
    logic [4:0] hi;
    logic [4:0] lo;
    y  = x;
    hi = nibble_of(y.st.held_digit);
    lo = nibble_of(c);
    if (y.st.held_digit_valid) begin
      if (hi[4] && lo[4]) begin
        y = put_result(y, {hi[3:0], lo[3:0]}, 1'b1);
        y = clear_escape(y);
        return y;
      end
      y = put_result(y, ChPercent, 1'b1);
      y = put_result(y, y.st.held_digit, 1'b1);
      y = clear_escape(y);
    end else if (y.st.held_percent) begin
      if (lo[4]) begin
        y.st.held_digit       = c;
        y.st.held_digit_valid = 1'b1;
        return y;
      end
      y = put_result(y, ChPercent, 1'b1);
      y.st.held_percent = 1'b0;
    end
    if (c == ChPercent) begin
      y.st.held_percent = 1'b1;
    end else begin
      y = put_result(y, c, 1'b1);
    end
    return y;
  endfunction

  // One content byte of the current line.
  function automatic ctx_t line_byte(ctx_t x, logic [7:0] c);
    ctx_t y;
    y = x;
    unique case (y.st.phase)
      PH_LINE_START: begin
        if (c == ChSlash) begin
          y.st.phase = PH_PATH;
          y = decode_byte(y, c);
        end else if (c == ChLowF) begin
          y.st.phase = PH_F;
        end else begin
          y.st.phase = PH_SKIP;
        end
      end
      PH_F:    y.st.phase = (c == ChLowI)  ? PH_FI    : PH_SKIP;
      PH_FI:   y.st.phase = (c == ChLowL)  ? PH_FIL   : PH_SKIP;
      PH_FIL:  y.st.phase = (c == ChLowE)  ? PH_FILE  : PH_SKIP;
      PH_FILE: y.st.phase = (c == ChColon) ? PH_COLON : PH_SKIP;
      PH_COLON: begin
        if (c == ChSlash) begin
          y.st.phase = PH_COLON_SL;
        end else begin
          y.st.phase = PH_PATH;
          y = decode_byte(y, c);
        end
      end
      PH_COLON_SL: begin
        if (c == ChSlash) begin
          y.st.phase = PH_AUTHORITY;
        end else begin
          y.st.phase = PH_PATH;
          y = decode_byte(y, ChSlash);
          y = decode_byte(y, c);
        end
      end
      PH_AUTHORITY: begin
        if (c == ChSlash) begin
          y.st.phase = PH_PATH;
          y = decode_byte(y, c);
        end
      end
      PH_PATH: y = decode_byte(y, c);
      default: y.st.phase = PH_SKIP;
    endcase
    return y;
  endfunction

  // Marks the last result as path end, or adds a bare end.
  function automatic ctx_t finish_path(ctx_t x);
    ctx_t y;
    y = x;
    if (y.out.cnt != 3'd0) begin
      y.out.res[2'(y.out.cnt - 3'd1)].path_end = 1'b1;
    end else begin
      y = put_result(y, 8'h00, 1'b0);
      y.out.res[0].path_end = 1'b1;
    end
    return y;
  endfunction

  function automatic ctx_t end_line(ctx_t x);
    ctx_t y;
    y = x;
    unique case (y.st.phase)
      PH_COLON: y = finish_path(y);
      PH_COLON_SL: begin
        y = put_result(y, ChSlash, 1'b1);
        y = finish_path(y);
      end
      PH_PATH: begin
        if (y.st.held_digit_valid) begin
          y = put_result(y, ChPercent, 1'b1);
          y = put_result(y, y.st.held_digit, 1'b1);
        end else if (y.st.held_percent) begin
          y = put_result(y, ChPercent, 1'b1);
        end
        y = finish_path(y);
      end
      default: ;
    endcase
    y.st.phase   = PH_LINE_START;
    y            = clear_escape(y);
    y.st.held_cr = 1'b0;
    return y;
  endfunction

endpackage

// ----- sv/ulpe_front.sv -----
// Front end: line parser and percent decoder, one input beat per cycle while accept_i is high.
module ulpe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_data_i,
  output logic               bundle_push_o,
  output ulpe_pkg::bundle_t  bundle_o
);

  ulpe_pkg::pstate_t st_q, st_d;
  ulpe_pkg::ctx_t    ctx;

  always_comb begin
    ctx.st  = st_q;
    ctx.out = '0;
    if (data_byte_i == ulpe_pkg::ChLf) begin
      ctx.st.held_cr = 1'b0;
      ctx = ulpe_pkg::end_line(ctx);
    end else begin
      // a held CR not followed by LF is plain content
      if (ctx.st.held_cr) begin
        ctx.st.held_cr = 1'b0;
        ctx = ulpe_pkg::line_byte(ctx, ulpe_pkg::ChCr);
      end
      if (data_byte_i == ulpe_pkg::ChCr) begin
        if (end_of_data_i) begin
          ctx = ulpe_pkg::end_line(ctx);
        end else begin
          ctx.st.held_cr = 1'b1;
        end
      end else begin
        ctx = ulpe_pkg::line_byte(ctx, data_byte_i);
        if (end_of_data_i) begin
          ctx = ulpe_pkg::end_line(ctx);
        end
      end
    end
    st_d = accept_i ? ctx.st : st_q;
  end

  assign bundle_push_o = accept_i && (ctx.out.cnt != 3'd0);
  assign bundle_o      = ctx.out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: ulpe_pkg::PH_LINE_START, default: '0};
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// ----- sv/ulpe_queue.sv -----
// Small register queue of result bundles between front and back ends.
module ulpe_queue #(
  parameter int Depth = ulpe_pkg::QueueDepthDf
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ulpe_pkg::bundle_t data_i,
  output logic              full_o,
  input  logic              deq_i,
  output logic              valid_o,
  output ulpe_pkg::bundle_t head_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  ulpe_pkg::bundle_t mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_deq;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_deq  = deq_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_deq) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !do_deq) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && do_deq) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- sv/ulpe_back.sv -----
// Back end: walks the head bundle one result per pop.
module ulpe_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  ulpe_pkg::bundle_t head_i,
  output logic              deq_o,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        path_byte_o,
  output logic              byte_valid_o,
  output logic              path_end_o
);

  logic [1:0]      idx_q, idx_d;
  ulpe_pkg::res_t  cur;
  logic            last;
  logic            take;

  assign cur          = head_i.res[idx_q];
  assign last         = ({1'b0, idx_q} + 3'd1) == head_i.cnt;
  assign take         = pop && head_valid_i;
  assign deq_o        = take && last;
  assign empty        = !head_valid_i;
  assign path_byte_o  = cur.path_byte;
  assign byte_valid_o = cur.byte_valid;
  assign path_end_o   = cur.path_end;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ----- sv/uri_list_path_extractor.sv -----
// Top level of the uri-list path extractor: parser, bundle queue, result walker.
//
// Usage:
//   Input side is a queue write port: drive data_byte_i / end_of_data_i with
//   push; a beat is taken at a rising edge with push high and full low.
//   Each byte yields zero to four results (decoded path bytes, or a bare
//   path end with byte_valid_o low); the last result of a path has
//   path_end_o set. Lines end at LF; CR before LF or end of data is dropped.
//   Output side is a queue read port: while empty is low the oldest result
//   sits on path_byte_o / byte_valid_o / path_end_o; pop takes it.
//   A result is registered in the bundle queue and shown once the results
//   ahead of it are popped. Throughput: one input byte per cycle while full
//   is low; results drain one per cycle while pop is high, so bursts are
//   absorbed by the bundle queue (QueueDepth bundles of up to four results each).
//   If the receiver stalls, the queue fills and full rises; the parser
//   state advances only on taken beats, so nothing is lost.
//   Reset clears the parser to line start and empties the queue; an
//   end_of_data beat returns the parser to the same state.
module uri_list_path_extractor #(
  parameter int QueueDepth = ulpe_pkg::QueueDepthDf
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_data_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] path_byte_o,
  output logic       byte_valid_o,
  output logic       path_end_o
);

  logic              accept;
  logic              bundle_push;
  ulpe_pkg::bundle_t bundle;
  logic              head_valid;
  ulpe_pkg::bundle_t head;
  logic              deq;

  // beats that yield nothing still advance the parser
  assign accept = push && !full;

  ulpe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_data_i (end_of_data_i),
    .bundle_push_o (bundle_push),
    .bundle_o      (bundle)
  );

  ulpe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bundle_push),
    .data_i  (bundle),
    .full_o  (full),
    .deq_i   (deq),
    .valid_o (head_valid),
    .head_o  (head)
  );

  ulpe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .deq_o        (deq),
    .pop          (pop),
    .empty        (empty),
    .path_byte_o  (path_byte_o),
    .byte_valid_o (byte_valid_o),
    .path_end_o   (path_end_o)
  );

endmodule

// ----- sv/ulpe_checker.sv -----
// Port-level checks of the uri-list path extractor, bound to the top level.
module ulpe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] path_byte_o,
  input logic       byte_valid_o,
  input logic       path_end_o
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty after reset");

  // a bare result is always a path end with a zero byte
  a_bare_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !byte_valid_o) |-> (path_end_o && path_byte_o == 8'h00))
    else $error("bare result without path end");

  // the queue fills only from a taken input beat
  a_full_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an input beat");

  // space frees up only when a result beat leaves
  a_full_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(full) |-> $past(pop && !empty))
    else $error("full dropped without a pop");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(path_byte_o) &&
                          $stable(byte_valid_o) && $stable(path_end_o)))
    else $error("stalled result changed");

endmodule

bind uri_list_path_extractor ulpe_checker u_ulpe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .path_byte_o  (path_byte_o),
  .byte_valid_o (byte_valid_o),
  .path_end_o   (path_end_o)
);
